// ----- rtl/crlp_pkg.sv -----
// ----------------------------------------------------------------------------
// Cross reply line parser package
// Item types, status codes, sizes and prefix tables shared by the parser.
// ----------------------------------------------------------------------------
package crlp_pkg;

   localparam int LINE_LIMIT_DEFAULT = 50;
   localparam int VALUE_BITS         = 16;
   localparam int ACC_BITS           = VALUE_BITS + 1;
   localparam int OFFSET_BITS        = 15;
   localparam int COUNT_BITS         = 8;

   localparam logic [OFFSET_BITS-1:0] MAX_OFFSET_RESET = OFFSET_BITS'(100);

   typedef enum logic [1:0] {
      STATUS_CROSS        = 2'd0,
      STATUS_NO_CROSS     = 2'd1,
      STATUS_PARSE_ERROR  = 2'd2,
      STATUS_OUT_OF_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] line_byte;
      logic       end_of_line;
   } req_item_type;

   typedef struct packed {
      status_type                   status;
      logic signed [VALUE_BITS-1:0] offset_x;
      logic signed [VALUE_BITS-1:0] offset_y;
      logic signed [VALUE_BITS-1:0] confidence;
   } rsp_item_type;

   // "NOCROSS"
   function automatic logic [7:0] no_cross_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0:    c = 8'h4E;
         3'd1:    c = 8'h4F;
         3'd2:    c = 8'h43;
         3'd3:    c = 8'h52;
         3'd4:    c = 8'h4F;
         3'd5:    c = 8'h53;
         3'd6:    c = 8'h53;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // "CROSS,"
   function automatic logic [7:0] cross_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0:    c = 8'h43;
         3'd1:    c = 8'h52;
         3'd2:    c = 8'h4F;
         3'd3:    c = 8'h53;
         3'd4:    c = 8'h53;
         3'd5:    c = 8'h2C;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ----- rtl/cross_reply_line_parser.sv -----
// ----------------------------------------------------------------------------
// Cross reply line parser
// Streams a camera reply line byte by byte and reports cross offsets.
// ----------------------------------------------------------------------------
// A byte is taken in every cycle unless a last byte waits behind a stalled
// result; req_stall then holds the input until that result is taken. A byte is
// held in an input register, then parsed combinationally into the line
// state; the byte flagged end_of_line also loads the result register, so its
// result passes through the input register and then the result register. The
// longest path is the digit step (multiply by ten, add, saturate).
// max_offset may be written at any time the parser is idle; csr_ready is
// always high.
module cross_reply_line_parser #(
   parameter int LINE_LIMIT = crlp_pkg::LINE_LIMIT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  crlp_pkg::req_item_type              req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output crlp_pkg::rsp_item_type              rsp_item,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [crlp_pkg::OFFSET_BITS-1:0]    csr_max_offset
);

   localparam int VB = crlp_pkg::VALUE_BITS;
   localparam int AB = crlp_pkg::ACC_BITS;
   localparam int CB = crlp_pkg::COUNT_BITS;
   localparam int PB = AB + 3;
   localparam logic [CB:0]   PARSE_LIMIT = (CB + 1)'(LINE_LIMIT - 1);
   localparam logic [AB-1:0] MAG_LIMIT   = AB'(1) << (VB - 1);
   localparam logic [CB-1:0] COUNT_MAX   = {CB{1'b1}};

   typedef enum logic [3:0] {
      PH_PREFIX  = 4'd0,
      PH_SPACE   = 4'd1,
      PH_SIGN    = 4'd2,
      PH_DIGITS  = 4'd3,
      PH_DONE    = 4'd4,
      PH_NOCROSS = 4'd5,
      PH_FAIL    = 4'd6
   } phase_type;

   typedef struct packed {
      logic [CB-1:0]        byte_count;
      phase_type            phase;
      logic [2:0]           prefix_pos;
      logic                 flag_no;
      logic                 flag_yes;
      logic [1:0]           field_index;
      logic                 negative_sign;
      logic                 digit_seen;
      logic [AB-1:0]        accumulator;
      logic signed [VB-1:0] value_0;
      logic signed [VB-1:0] value_1;
      logic signed [VB-1:0] value_2;
      logic                 text_ended;
   } line_state_type;

   localparam line_state_type LINE_CLEAR = '{
      byte_count:    '0,
      phase:         PH_PREFIX,
      prefix_pos:    '0,
      flag_no:       1'b1,
      flag_yes:      1'b1,
      field_index:   '0,
      negative_sign: 1'b0,
      digit_seen:    1'b0,
      accumulator:   '0,
      value_0:       '0,
      value_1:       '0,
      value_2:       '0,
      text_ended:    1'b0
   };

   logic                            s1_valid_ff;
   crlp_pkg::req_item_type          s1_item_ff;
   line_state_type                  line_ff;
   line_state_type                  line_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   crlp_pkg::rsp_item_type          rsp_item_ff;
   crlp_pkg::rsp_item_type          rsp_item_in;
   logic [crlp_pkg::OFFSET_BITS-1:0] max_offset_ff;
   logic                            advance;
   logic                            step;
   logic                            load_rsp;

   function automatic logic signed [VB-1:0] commit_value(input logic neg,
                                                          input logic [AB-1:0] acc);
      logic [AB-1:0] m;
      logic [AB-1:0] n;
      if (neg) begin
         m = (acc > MAG_LIMIT) ? MAG_LIMIT : acc;
         n = AB'(0) - m;
      end else begin
         n = (acc > MAG_LIMIT - AB'(1)) ? MAG_LIMIT - AB'(1) : acc;
      end
      return n[VB-1:0];
   endfunction

   function automatic logic [AB-1:0] magnitude(input logic signed [VB-1:0] v);
      logic [AB-1:0] w;
      w = {v[VB-1], v};
      return v[VB-1] ? AB'(0) - w : w;
   endfunction

   function automatic line_state_type store_value(input line_state_type s);
      line_state_type r;
      logic signed [VB-1:0] v;
      r = s;
      v = commit_value(s.negative_sign, s.accumulator);
      case (s.field_index)
         2'd1:    r.value_1 = v;
         2'd2:    r.value_2 = v;
         default: r.value_0 = v;
      endcase
      return r;
   endfunction

   assign advance   = !(s1_valid_ff && s1_item_ff.end_of_line && rsp_valid_ff && rsp_stall);
   assign step      = s1_valid_ff && advance;
   assign load_rsp  = step && s1_item_ff.end_of_line;
   assign req_stall = s1_valid_ff && !advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   always_comb begin
      line_state_type        s;
      line_state_type        f;
      logic [7:0]            c;
      logic                  digit;
      logic                  space;
      logic [3:0]            d;
      logic [PB-1:0]         prod;
      logic [AB-1:0]         lim;
      crlp_pkg::status_type  st;

      s     = line_ff;
      c     = s1_item_ff.line_byte;
      digit = (c >= 8'h30) && (c <= 8'h39);
      space = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
      d     = c[3:0];
      prod  = PB'(line_ff.accumulator) * PB'(10) + PB'(d);
      lim   = AB'(max_offset_ff);

      s.byte_count = (line_ff.byte_count == COUNT_MAX) ? COUNT_MAX
                                                       : line_ff.byte_count + CB'(1);

      if (!line_ff.text_ended && ({1'b0, line_ff.byte_count} < PARSE_LIMIT)) begin
         if (c == 8'h00) begin
            s.text_ended = 1'b1;
         end else begin
            case (line_ff.phase)
               PH_PREFIX: begin
                  if (line_ff.prefix_pos < 3'd7 &&
                      c != crlp_pkg::no_cross_char(line_ff.prefix_pos)) begin
                     s.flag_no = 1'b0;
                  end
                  if (line_ff.prefix_pos < 3'd6 &&
                      c != crlp_pkg::cross_char(line_ff.prefix_pos)) begin
                     s.flag_yes = 1'b0;
                  end
                  s.prefix_pos = line_ff.prefix_pos + 3'd1;
                  if (s.flag_no && s.prefix_pos == 3'd7) begin
                     s.phase = PH_NOCROSS;
                  end else if (s.flag_yes && s.prefix_pos == 3'd6) begin
                     s.phase         = PH_SPACE;
                     s.field_index   = 2'd0;
                     s.negative_sign = 1'b0;
                     s.digit_seen    = 1'b0;
                     s.accumulator   = '0;
                  end else if (!s.flag_no && !s.flag_yes) begin
                     s.phase = PH_FAIL;
                  end
               end
               PH_SPACE, PH_SIGN: begin
                  if (digit) begin
                     s.digit_seen  = 1'b1;
                     s.accumulator = AB'(d);
                     s.phase       = PH_DIGITS;
                  end else if (line_ff.phase == PH_SPACE && space) begin
                     s.phase = PH_SPACE;
                  end else if (line_ff.phase == PH_SPACE && (c == 8'h2B || c == 8'h2D)) begin
                     s.negative_sign = (c == 8'h2D);
                     s.phase         = PH_SIGN;
                  end else begin
                     s.phase = PH_FAIL;
                  end
               end
               PH_DIGITS: begin
                  if (digit) begin
                     s.accumulator = (prod > PB'(MAG_LIMIT)) ? MAG_LIMIT : prod[AB-1:0];
                  end else if (line_ff.field_index >= 2'd2) begin
                     s       = store_value(s);
                     s.phase = PH_DONE;
                  end else if (c == 8'h2C) begin
                     s               = store_value(s);
                     s.field_index   = line_ff.field_index + 2'd1;
                     s.negative_sign = 1'b0;
                     s.digit_seen    = 1'b0;
                     s.accumulator   = '0;
                     s.phase         = PH_SPACE;
                  end else begin
                     s.phase = PH_FAIL;
                  end
               end
               default: begin
                  s.phase = line_ff.phase;
               end
            endcase
         end
      end

      // close the line: commit a pending last value and grade it
      f = s;
      if (f.phase == PH_DIGITS && f.field_index >= 2'd2 && f.digit_seen) begin
         f       = store_value(f);
         f.phase = PH_DONE;
      end
      if (s.byte_count < CB'(3)) begin
         st = crlp_pkg::STATUS_PARSE_ERROR;
      end else if (s.phase == PH_NOCROSS) begin
         st = crlp_pkg::STATUS_NO_CROSS;
      end else if (f.phase != PH_DONE) begin
         st = crlp_pkg::STATUS_PARSE_ERROR;
      end else if (magnitude(line_ff.value_0) > lim || magnitude(line_ff.value_1) > lim) begin
         st = crlp_pkg::STATUS_OUT_OF_RANGE;
      end else begin
         st = crlp_pkg::STATUS_CROSS;
      end

      rsp_item_in        = rsp_item_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      line_in            = line_ff;
      if (step) begin
         line_in = s;
      end
      if (load_rsp) begin
         line_in                = LINE_CLEAR;
         rsp_valid_in           = 1'b1;
         rsp_item_in.status     = st;
         if (st == crlp_pkg::STATUS_CROSS || st == crlp_pkg::STATUS_OUT_OF_RANGE) begin
            rsp_item_in.offset_x   = f.value_0;
            rsp_item_in.offset_y   = f.value_1;
            rsp_item_in.confidence = f.value_2;
         end else begin
            rsp_item_in.offset_x   = '0;
            rsp_item_in.offset_y   = '0;
            rsp_item_in.confidence = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         line_ff       <= LINE_CLEAR;
         max_offset_ff <= crlp_pkg::MAX_OFFSET_RESET;
      end else begin
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         rsp_valid_ff <= rsp_valid_in;
         line_ff      <= line_in;
         if (csr_valid && csr_ready) begin
            max_offset_ff <= csr_max_offset;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_item_ff <= req_item;
      end
      rsp_item_ff <= rsp_item_in;
   end

   a_empty_values : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_item_ff.status == crlp_pkg::STATUS_NO_CROSS ||
                       rsp_item_ff.status == crlp_pkg::STATUS_PARSE_ERROR)
      |-> rsp_item_ff.offset_x == '0 && rsp_item_ff.offset_y == '0 &&
          rsp_item_ff.confidence == '0)
      else $error("empty result carries values");

   a_line_cleared : assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> line_ff.byte_count == '0 && line_ff.phase == PH_PREFIX)
      else $error("line state not cleared after last item");

   a_no_stray_result : assert property (@(posedge clock) disable iff (reset)
      step && !s1_item_ff.end_of_line && !(rsp_valid_ff && rsp_stall) |=> !rsp_valid_ff)
      else $error("result produced by an inner byte");

   a_nocross_prefix : assert property (@(posedge clock) disable iff (reset)
      line_ff.phase == PH_NOCROSS |-> line_ff.prefix_pos == 3'd7)
      else $error("no-cross phase without full prefix");

endmodule

// ----- verif/crlp_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// Cross reply line parser scoreboard
// Follows each accepted line byte with its own line state and queues the reply
// that a frame's last byte must produce. Compares each reply field by field.
// ----------------------------------------------------------------------------
package crlp_tb_pkg;

   localparam int TEXT_BYTES = crlp_pkg::LINE_LIMIT_DEFAULT - 1;
   localparam int VB         = crlp_pkg::VALUE_BITS;
   localparam int OB         = crlp_pkg::OFFSET_BITS;
   localparam int MAG_LIMIT  = 1 << (VB - 1);

   typedef enum logic [2:0] {
      SCAN_PREFIX,
      SCAN_SPACE,
      SCAN_SIGN,
      SCAN_DIGITS,
      SCAN_DONE,
      SCAN_NO_CROSS,
      SCAN_FAIL
   } scan_phase_type;

   class reply_scoreboard;

      crlp_pkg::rsp_item_type       expected_replies[$];
      logic [OB-1:0]                max_offset;
      int                           byte_count;
      scan_phase_type               phase;
      int                           prefix_pos;
      bit                           no_cross_possible;
      bit                           cross_possible;
      int                           field_index;
      bit                           negative;
      bit                           digit_seen;
      int                           magnitude;
      logic signed [VB-1:0]         field_values[3];
      bit                           text_ended;
      int                           failures;
      int                           status_seen[4];
      string                        no_cross_word = "NOCROSS";
      string                        cross_word    = "CROSS,";

      function new();
         max_offset = crlp_pkg::MAX_OFFSET_RESET;
         failures   = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
         clear_line();
      endfunction

      function void set_max_offset(logic [OB-1:0] value);
         max_offset = value;
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction

      function void clear_line();
         byte_count        = 0;
         phase             = SCAN_PREFIX;
         prefix_pos        = 0;
         no_cross_possible = 1'b1;
         cross_possible    = 1'b1;
         field_index       = 0;
         text_ended        = 1'b0;
         foreach (field_values[i]) field_values[i] = '0;
         start_number();
      endfunction

      function void start_number();
         negative   = 1'b0;
         digit_seen = 1'b0;
         magnitude  = 0;
      endfunction

      function void commit_number();
         int v;
         if (negative) begin
            v = (magnitude > MAG_LIMIT) ? -MAG_LIMIT : -magnitude;
         end else begin
            v = (magnitude > MAG_LIMIT - 1) ? MAG_LIMIT - 1 : magnitude;
         end
         field_values[field_index] = v[VB-1:0];
      endfunction

      function void take_char(logic [7:0] c);
         bit is_digit;
         bit is_space;
         is_digit = (c >= "0") && (c <= "9");
         is_space = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
         case (phase)
            SCAN_PREFIX: begin
               if (prefix_pos < 7 && c != no_cross_word[prefix_pos]) no_cross_possible = 1'b0;
               if (prefix_pos < 6 && c != cross_word[prefix_pos]) cross_possible = 1'b0;
               prefix_pos = (prefix_pos + 1) % 8;
               if (no_cross_possible && prefix_pos == 7) begin
                  phase = SCAN_NO_CROSS;
               end else if (cross_possible && prefix_pos == 6) begin
                  phase       = SCAN_SPACE;
                  field_index = 0;
                  start_number();
               end else if (!no_cross_possible && !cross_possible) begin
                  phase = SCAN_FAIL;
               end
            end
            SCAN_SPACE, SCAN_SIGN: begin
               if (is_digit) begin
                  digit_seen = 1'b1;
                  magnitude  = c - "0";
                  phase      = SCAN_DIGITS;
               end else if (phase == SCAN_SPACE && is_space) begin
               end else if (phase == SCAN_SPACE && (c == "+" || c == "-")) begin
                  negative = (c == "-");
                  phase    = SCAN_SIGN;
               end else begin
                  phase = SCAN_FAIL;
               end
            end
            SCAN_DIGITS: begin
               if (is_digit) begin
                  magnitude = magnitude * 10 + (c - "0");
                  if (magnitude > MAG_LIMIT) magnitude = MAG_LIMIT;
               end else if (field_index >= 2) begin
                  commit_number();
                  phase = SCAN_DONE;
               end else if (c == ",") begin
                  commit_number();
                  field_index++;
                  start_number();
                  phase = SCAN_SPACE;
               end else begin
                  phase = SCAN_FAIL;
               end
            end
            default: begin
            end
         endcase
      endfunction

      function crlp_pkg::status_type close_line();
         int x;
         int y;
         int lim;
         if (byte_count < 3) return crlp_pkg::STATUS_PARSE_ERROR;
         if (phase == SCAN_NO_CROSS) return crlp_pkg::STATUS_NO_CROSS;
         if (phase == SCAN_DIGITS && field_index >= 2 && digit_seen) begin
            commit_number();
            phase = SCAN_DONE;
         end
         if (phase != SCAN_DONE) return crlp_pkg::STATUS_PARSE_ERROR;
         x   = field_values[0];
         y   = field_values[1];
         lim = max_offset;
         if (x > lim || x < -lim || y > lim || y < -lim) return crlp_pkg::STATUS_OUT_OF_RANGE;
         return crlp_pkg::STATUS_CROSS;
      endfunction

      function void note_byte(crlp_pkg::req_item_type item);
         int                     pos;
         crlp_pkg::rsp_item_type reply;
         pos = byte_count;
         if (byte_count < 255) byte_count++;
         if (!text_ended && pos < TEXT_BYTES) begin
            if (item.line_byte == 8'h00) text_ended = 1'b1;
            else take_char(item.line_byte);
         end
         if (item.end_of_line) begin
            reply        = '0;
            reply.status = close_line();
            if (reply.status == crlp_pkg::STATUS_CROSS ||
                reply.status == crlp_pkg::STATUS_OUT_OF_RANGE) begin
               reply.offset_x   = field_values[0];
               reply.offset_y   = field_values[1];
               reply.confidence = field_values[2];
            end
            expected_replies.push_back(reply);
            clear_line();
         end
      endfunction

      function void compare_field(string field, logic signed [31:0] want,
                                  logic signed [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            failures++;
         end
      endfunction

      function void check_reply(crlp_pkg::rsp_item_type got);
         crlp_pkg::rsp_item_type want;
         if (expected_replies.size() == 0) begin
            $error("reply with none expected: status %0d x %0d y %0d confidence %0d",
                   got.status, got.offset_x, got.offset_y, got.confidence);
            failures++;
            return;
         end
         want = expected_replies.pop_front();
         status_seen[int'(want.status)]++;
         compare_field("status", want.status, got.status);
         compare_field("offset_x", want.offset_x, got.offset_x);
         compare_field("offset_y", want.offset_y, got.offset_y);
         compare_field("confidence", want.confidence, got.confidence);
      endfunction

   endclass

endpackage

// ----- verif/tb_cross_reply_line_parser.sv -----
// ----------------------------------------------------------------------------
// Cross reply line parser testbench
// Feeds framed reply lines, first a directed set of edge cases, then random
// well-formed, damaged, long and noise lines under several max_offset
// settings, with random sender gaps and random receiver stalls.
// ----------------------------------------------------------------------------
module tb_cross_reply_line_parser;

   localparam int IDLE_LIMIT    = 1000;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASE_BYTES   = 220;
   localparam int OB            = crlp_pkg::OFFSET_BITS;

   typedef logic [7:0] line_text_type[$];

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_stall;
   crlp_pkg::req_item_type req_item       = '0;
   logic                   rsp_valid;
   logic                   rsp_stall      = 1'b0;
   crlp_pkg::rsp_item_type rsp_item;
   logic                   csr_valid      = 1'b0;
   logic                   csr_ready;
   logic [OB-1:0]          csr_max_offset = crlp_pkg::MAX_OFFSET_RESET;

   crlp_tb_pkg::reply_scoreboard scoreboard;
   int              current_max  = crlp_pkg::MAX_OFFSET_RESET;
   int              burst_left   = 0;
   int              bytes_sent   = 0;
   int              frames_sent  = 0;
   int              idle_cycles  = 0;
   int              stall_window = 0;
   int              stall_mode   = 0;
   int              stall_run    = 0;

   always #10 clock = ~clock;

   cross_reply_line_parser u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_item       (rsp_item),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_max_offset (csr_max_offset)
   );

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_window == 0) begin
            stall_window = $urandom_range(400, 50);
            stall_mode   = $urandom_range(3, 0);
         end
         stall_window--;
         if (stall_run > 0) begin
            stall_run--;
         end else begin
            stall_run = (stall_mode == 2) ? $urandom_range(12, 0) : 0;
            rsp_stall <= (stall_mode != 0) && ($urandom_range(3, 0) < stall_mode);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) scoreboard.check_reply(rsp_item);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no handshake for %0d cycles, %0d replies outstanding",
                  idle_cycles, scoreboard.pending());
         $display("** cross_reply_line_parser: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] value, input logic last);
      crlp_pkg::req_item_type item;
      int                     gap;
      item.line_byte   = value;
      item.end_of_line = last;
      req_item  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      scoreboard.note_byte(item);
      bytes_sent++;
      if (last) frames_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(9, 0) == 0) ? $urandom_range(300, 100)
                                                  : $urandom_range(30, 1);
         gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(20, 1);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_frame(input line_text_type line);
      if (line.size() == 0) line.push_back(8'($urandom_range(255, 0)));
      for (int i = 0; i < line.size(); i++) send_byte(line[i], i == line.size() - 1);
   endtask

   // hold the sender until every reply is back, then let the parser settle
   task automatic wait_for_replies();
      req_valid <= 1'b0;
      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_offset(input int value);
      csr_valid      <= 1'b1;
      csr_max_offset <= value[OB-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      scoreboard.set_max_offset(value[OB-1:0]);
      current_max = value;
   endtask

   function automatic void append_text(ref line_text_type line, input string s);
      for (int i = 0; i < s.len(); i++) line.push_back(s[i]);
   endfunction

   function automatic void append_number(ref line_text_type line, input int spaces);
      int k;
      int value;
      repeat (spaces) begin
         k = $urandom_range(5, 0);
         line.push_back(k == 0 ? 8'd32 : 8'(8 + k));
      end
      case ($urandom_range(3, 0))
         1: line.push_back("+");
         2: line.push_back("-");
         default: begin
         end
      endcase
      case ($urandom_range(6, 0))
         0, 1:    value = $urandom_range(current_max + 2, 0);
         2:       value = $urandom_range(200, 0);
         3:       value = $urandom_range(99999, 0);
         4:       value = $urandom_range(32769, 32766);
         5:       value = $urandom_range(9, 0);
         default: value = -1;
      endcase
      if (value < 0) begin
         repeat ($urandom_range(12, 6)) line.push_back(8'("0" + $urandom_range(9, 0)));
      end else begin
         if ($urandom_range(5, 0) == 0) append_text(line, "00");
         append_text(line, $sformatf("%0d", value));
      end
   endfunction

   function automatic void append_trailer(ref line_text_type line);
      case ($urandom_range(5, 0))
         0: append_text(line, "\015\n");
         1: repeat ($urandom_range(5, 1)) line.push_back(8'($urandom_range(126, 32)));
         2: begin
            line.push_back(8'h00);
            repeat ($urandom_range(3, 0)) line.push_back(8'($urandom_range(255, 0)));
         end
         3: append_text(line, ",7");
         default: begin
         end
      endcase
   endfunction

   // a field picked by long_field gets 15 to 45 leading spaces, so that it can cross the text limit
   function automatic void build_cross_line(ref line_text_type line, input int long_field);
      append_text(line, "CROSS,");
      for (int f = 0; f < 3; f++) begin
         if (f > 0) line.push_back(",");
         append_number(line, (f == long_field) ? $urandom_range(45, 15) :
                             (($urandom_range(3, 0) == 0) ? $urandom_range(2, 1) : 0));
      end
      append_trailer(line);
   endfunction

   task automatic send_text(input string s);
      line_text_type line;
      append_text(line, s);
      send_frame(line);
   endtask

   task automatic run_random_phase(input int max_offset_value);
      line_text_type line;
      int            start_bytes;
      int            pick;
      int            cut;
      write_max_offset(max_offset_value);
      start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < PHASE_BYTES) begin
         line.delete();
         pick = $urandom_range(99, 0);
         if (pick < 50) begin
            build_cross_line(line, -1);
         end else if (pick < 60) begin
            append_text(line, "NOCROSS");
            append_trailer(line);
         end else if (pick < 75) begin
            build_cross_line(line, -1);
            if ($urandom_range(1, 0) == 1) begin
               line[$urandom_range(line.size() - 1, 0)] = 8'($urandom_range(255, 0));
            end else begin
               cut = $urandom_range(line.size() - 1, 1);
               while (line.size() > cut) void'(line.pop_back());
            end
         end else if (pick < 85) begin
            if ($urandom_range(1, 0) == 1) append_text(line, "NOCROSS");
            else append_text(line, "CROSS,");
            cut = $urandom_range(line.size() - 1, 0);
            while (line.size() > cut) void'(line.pop_back());
            repeat ($urandom_range(6, 1)) line.push_back(8'($urandom_range(255, 0)));
         end else if (pick < 95) begin
            build_cross_line(line, $urandom_range(2, 0));
         end else begin
            repeat ($urandom_range(2, 1)) line.push_back(8'($urandom_range(255, 0)));
         end
         send_frame(line);
         if ($urandom_range(19, 0) == 0) wait_for_replies();
      end
      wait_for_replies();
   endtask

   initial begin
      line_text_type line;
      scoreboard = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_text("CROSS,12,-34,56");
      send_text("NOCROSS");
      send_text("NOCROSS,5,5,5\015\n");
      send_text("X");
      send_text("NO");
      send_text("ABC");
      send_text("CROSS, \t+7,\n-0,\015 99 tail");
      send_text("CROSS,101,0,1");
      send_text("CROSS,0,-101,1");
      send_text("CROSS,-100,100,-5");
      send_text("CROSS,1,2");
      send_text("CROSS,1;2,3");
      send_text("CROSS,1,2,");
      send_text("CROSS,-,1,2");
      send_text("CROSS,99999,-99999,123456");
      line.delete();
      append_text(line, "CROSS,1,2");
      line.push_back(8'h00);
      append_text(line, "3");
      send_frame(line);
      line.delete();
      append_text(line, "CROSS,1,2,3");
      line.push_back(8'h00);
      line.push_back(8'hFF);
      send_frame(line);
      line.delete();
      repeat (3) line.push_back(8'h00);
      send_frame(line);
      line.delete();
      line.push_back(8'hFF);
      append_text(line, "NOCROSS");
      send_frame(line);
      line.delete();
      append_text(line, "CROSS,1,2,");
      repeat (37) line.push_back(" ");
      append_text(line, "12345");
      send_frame(line);
      line.delete();
      append_text(line, "CROSS,5,6,7");
      repeat (249) line.push_back(8'hFF);
      send_frame(line);
      wait_for_replies();

      write_max_offset(0);
      send_text("CROSS,0,0,5");
      send_text("CROSS,-1,0,0");
      send_text("CROSS,0,+1,0");
      wait_for_replies();

      write_max_offset(32767);
      send_text("CROSS,-32768,32767,-32769");
      send_text("CROSS,-32767,32767,0");
      wait_for_replies();

      run_random_phase($urandom_range(300, 0));
      run_random_phase(0);
      run_random_phase($urandom_range(32767, 0));
      run_random_phase(32767);

      wait_for_replies();
      $display("sent %0d bytes in %0d frames over directed and four random phases",
               bytes_sent, frames_sent);
      $display("replies: %0d cross, %0d no cross, %0d parse error, %0d out of range",
               scoreboard.status_seen[crlp_pkg::STATUS_CROSS],
               scoreboard.status_seen[crlp_pkg::STATUS_NO_CROSS],
               scoreboard.status_seen[crlp_pkg::STATUS_PARSE_ERROR],
               scoreboard.status_seen[crlp_pkg::STATUS_OUT_OF_RANGE]);
      if (scoreboard.failures == 0 && scoreboard.pending() == 0) begin
         $display("** cross_reply_line_parser: PASSED **");
      end else begin
         $display("** cross_reply_line_parser: FAILED **");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/crlp_pkg.sv
rtl/cross_reply_line_parser.sv
verif/crlp_tb_pkg.sv
verif/tb_cross_reply_line_parser.sv
